// ===== hdl/m4t_pkg.sv =====
// Shared constants, command codes, state codes and control types of the matrix transform unit.
package m4t_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;
    localparam int LANES         = 4;
    localparam int CMD_BITS      = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE    = 3'd0,
        CMD_IDENTITY = 3'd1,
        CMD_SCALE    = 3'd2,
        CMD_XFORM    = 3'd3,
        CMD_OPWRITE  = 3'd4,
        CMD_MULTIPLY = 3'd5,
        CMD_PRODUCT  = 3'd6,
        CMD_READ     = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       bypass;
        logic [1:0] row_index;
        logic       last;
    } emit_t;

endpackage

// ===== hdl/m4t_lane.sv =====
// One multiply-accumulate lane: fixed-point product with floor and clip, then running sum.
module m4t_lane #(
    parameter int FRAC_BITS = m4t_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = m4t_pkg::DEF_WORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        issue,
    input  logic                        first,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic signed [WORD_BITS-1:0] sprod,
    output logic signed [WORD_BITS+1:0] acc,
    output logic                        clip
);

    localparam int PW = 2 * WORD_BITS;

    logic signed [PW-1:0]          a_ext;
    logic signed [PW-1:0]          b_ext;
    logic signed [PW-1:0]          prod_reg;
    logic                          pv_reg;
    logic                          pfirst_reg;
    logic signed [PW-1:0]          shifted;
    logic                          pclip;
    logic signed [WORD_BITS+1:0]   acc_reg;
    logic signed [WORD_BITS+1:0]   acc_next;
    logic                          clip_reg;

    assign a_ext = a;
    assign b_ext = b;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= a_ext * b_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg     <= 1'b0;
            pfirst_reg <= 1'b0;
        end
        else
        begin
            pv_reg     <= issue;
            pfirst_reg <= first;
        end
    end

    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        pclip   = !((&shifted[PW-1:WORD_BITS-1]) || !(|shifted[PW-1:WORD_BITS-1]));
        if (pclip)
        begin
            sprod = shifted[PW-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                  : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        else
        begin
            sprod = shifted[WORD_BITS-1:0];
        end
        acc_next = (pfirst_reg ? '0 : acc_reg) + {{2{sprod[WORD_BITS-1]}}, sprod};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (pv_reg)
        begin
            acc_reg  <= acc_next;
            clip_reg <= pfirst_reg ? pclip : (clip_reg | pclip);
        end
    end

    assign acc  = acc_reg;
    assign clip = clip_reg;

endmodule

// ===== hdl/m4t_merge.sv =====
// Merge stage: clip the lane sums or pass a read row through, combine flags and hold the result transaction.
module m4t_merge #(
    parameter int WORD_BITS = m4t_pkg::DEF_WORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [WORD_BITS+1:0] lane_acc [m4t_pkg::LANES],
    input  logic                        lane_clip [m4t_pkg::LANES],
    input  logic signed [WORD_BITS-1:0] rd_row [m4t_pkg::LANES],
    input  m4t_pkg::emit_t              ctl,
    output logic signed [WORD_BITS-1:0] sat_val [m4t_pkg::LANES],
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [WORD_BITS-1:0]        out_word [m4t_pkg::LANES],
    output logic [1:0]                  out_row,
    output logic                        out_last,
    output logic                        out_sat
);

    logic                  sum_clip;
    logic                  valid_reg;
    logic [WORD_BITS-1:0]  word_reg [m4t_pkg::LANES];
    logic [1:0]            row_reg;
    logic                  last_reg;
    logic                  sat_reg;

    always_comb
    begin
        sum_clip = 1'b0;
        for (int i = 0; i < m4t_pkg::LANES; i++)
        begin
            if ((&lane_acc[i][WORD_BITS+1:WORD_BITS-1]) ||
                !(|lane_acc[i][WORD_BITS+1:WORD_BITS-1]))
            begin
                sat_val[i] = lane_acc[i][WORD_BITS-1:0];
            end
            else
            begin
                sum_clip   = 1'b1;
                sat_val[i] = lane_acc[i][WORD_BITS+1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                                      : {1'b0, {(WORD_BITS-1){1'b1}}};
            end
            sum_clip = sum_clip | lane_clip[i];
        end
    end

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= ctl.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && ctl.load)
        begin
            for (int i = 0; i < m4t_pkg::LANES; i++)
            begin
                word_reg[i] <= ctl.bypass ? rd_row[i] : sat_val[i];
            end
            row_reg  <= ctl.row_index;
            last_reg <= ctl.last;
            sat_reg  <= ctl.bypass ? 1'b0 : sum_clip;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_row   = row_reg;
    assign out_last  = last_reg;
    assign out_sat   = sat_reg;

endmodule

// ===== hdl/matrix4_transform_unit.sv =====
// Top level of the 4x4 matrix transform unit: command sequencer, matrices, lanes and merge stage.
//
//  channel  | dir | tdata                              | tuser              | tlast
//  s_axis   | in  | row, col, value, vec_x..vec_w      | command            | -
//  m_axis   | out | out_a, out_b, out_c, out_d         | row_index, saturated | last
//
// Element write, operand write and identity complete on acceptance; a row read goes straight to emit.
// Scale and transform run four steps through the four lanes.
// Multiply and product run four such row passes.
// Reset loads identity into the transform matrix and zero into the operand matrix.
// A stalled output holds the merge register; the sequencer waits on it before emitting.
module matrix4_transform_unit #(
    parameter int FRAC_BITS = m4t_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = m4t_pkg::DEF_WORD_BITS,
    localparam int IN_DW    = ((4 + 5 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_DW   = ((4 * WORD_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // row, col, value, vec_x, vec_y, vec_z, vec_w
    input  logic [2:0]        s_tuser,   // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // out_a, out_b, out_c, out_d
    output logic [2:0]        m_tuser,   // row_index, saturated
    output logic              m_tlast
);

    localparam int W = WORD_BITS;
    localparam logic signed [W-1:0] ONE =
        (FRAC_BITS >= W - 1) ? {1'b0, {(W-1){1'b1}}} : W'(1) << FRAC_BITS;

    m4t_pkg::state_t state_reg, state_next;
    m4t_pkg::cmd_t   cmd_reg;
    logic [1:0]      row_reg;
    logic [1:0]      k_reg, k_next;
    logic [1:0]      rowc_reg, rowc_next;
    logic [1:0]      kd1_reg;
    logic            issue_d1_reg;
    logic signed [W-1:0] value_reg;
    logic signed [W-1:0] vec_reg [m4t_pkg::LANES];
    logic signed [W-1:0] t_reg [16];
    logic signed [W-1:0] o_reg [16];

    logic                accept;
    m4t_pkg::cmd_t       in_cmd;
    logic [1:0]          in_row;
    logic [1:0]          in_col;
    logic signed [W-1:0] in_value;

    logic                issue;
    logic                first;
    logic signed [W-1:0] lane_a [m4t_pkg::LANES];
    logic signed [W-1:0] lane_b [m4t_pkg::LANES];
    logic signed [W-1:0] lane_sprod [m4t_pkg::LANES];
    logic signed [W+1:0] lane_acc [m4t_pkg::LANES];
    logic                lane_clip [m4t_pkg::LANES];
    logic signed [W-1:0] rd_row [m4t_pkg::LANES];
    logic signed [W-1:0] sat_val [m4t_pkg::LANES];
    logic [W-1:0]        out_word [m4t_pkg::LANES];
    logic                free;
    logic                emit_go;
    logic                out_row_last;
    m4t_pkg::emit_t      ctl;

    assign in_cmd   = m4t_pkg::cmd_t'(s_tuser);
    assign in_row   = s_tdata[1:0];
    assign in_col   = s_tdata[3:2];
    assign in_value = s_tdata[4 +: W];
    assign s_tready = (state_reg == m4t_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        issue = (state_reg == m4t_pkg::S_RUN);
        first = (cmd_reg == m4t_pkg::CMD_SCALE) || (k_reg == 2'd0);
        for (int i = 0; i < m4t_pkg::LANES; i++)
        begin
            rd_row[i] = t_reg[{row_reg, 2'(i)}];
            if (cmd_reg == m4t_pkg::CMD_MULTIPLY || cmd_reg == m4t_pkg::CMD_PRODUCT)
            begin
                lane_a[i] = t_reg[{rowc_reg, k_reg}];
                lane_b[i] = o_reg[{k_reg, 2'(i)}];
            end
            else
            begin
                lane_a[i] = t_reg[{2'(i), k_reg}];
                lane_b[i] = (cmd_reg == m4t_pkg::CMD_SCALE) ? value_reg : vec_reg[k_reg];
            end
        end
    end

    always_comb
    begin
        emit_go       = 1'b0;
        out_row_last  = (rowc_reg == 2'd3);
        ctl.load      = 1'b0;
        ctl.bypass    = (cmd_reg == m4t_pkg::CMD_READ);
        ctl.row_index = 2'd0;
        ctl.last      = 1'b1;
        unique case (cmd_reg)
            m4t_pkg::CMD_READ:
            begin
                ctl.row_index = row_reg;
                emit_go       = free;
            end
            m4t_pkg::CMD_PRODUCT:
            begin
                ctl.row_index = rowc_reg;
                ctl.last      = out_row_last;
                emit_go       = free;
            end
            m4t_pkg::CMD_XFORM:
            begin
                emit_go = free;
            end
            default:
            begin
                emit_go = 1'b1;
            end
        endcase
        if (cmd_reg == m4t_pkg::CMD_READ || cmd_reg == m4t_pkg::CMD_PRODUCT ||
            cmd_reg == m4t_pkg::CMD_XFORM)
        begin
            ctl.load = (state_reg == m4t_pkg::S_EMIT) && free;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        rowc_next  = rowc_reg;
        unique case (state_reg)
            m4t_pkg::S_IDLE:
            begin
                k_next    = 2'd0;
                rowc_next = 2'd0;
                if (accept)
                begin
                    unique case (in_cmd)
                        m4t_pkg::CMD_WRITE, m4t_pkg::CMD_IDENTITY,
                        m4t_pkg::CMD_OPWRITE: state_next = m4t_pkg::S_IDLE;
                        m4t_pkg::CMD_READ:    state_next = m4t_pkg::S_EMIT;
                        default:              state_next = m4t_pkg::S_RUN;
                    endcase
                end
            end
            m4t_pkg::S_RUN:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = m4t_pkg::S_WAIT;
                end
            end
            m4t_pkg::S_WAIT:
            begin
                state_next = m4t_pkg::S_EMIT;
            end
            m4t_pkg::S_EMIT:
            begin
                if (emit_go)
                begin
                    if ((cmd_reg == m4t_pkg::CMD_MULTIPLY || cmd_reg == m4t_pkg::CMD_PRODUCT)
                        && !out_row_last)
                    begin
                        rowc_next  = rowc_reg + 2'd1;
                        k_next     = 2'd0;
                        state_next = m4t_pkg::S_RUN;
                    end
                    else
                    begin
                        state_next = m4t_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = m4t_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= m4t_pkg::S_IDLE;
            cmd_reg      <= m4t_pkg::CMD_WRITE;
            k_reg        <= 2'd0;
            rowc_reg     <= 2'd0;
            kd1_reg      <= 2'd0;
            issue_d1_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            rowc_reg     <= rowc_next;
            kd1_reg      <= k_reg;
            issue_d1_reg <= issue;
            if (accept)
            begin
                cmd_reg <= in_cmd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg   <= in_row;
            value_reg <= in_value;
            for (int i = 0; i < m4t_pkg::LANES; i++)
            begin
                vec_reg[i] <= s_tdata[4 + W * (i + 1) +: W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t_reg[i] <= (i % 5 == 0) ? ONE : '0;
                o_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept && in_cmd == m4t_pkg::CMD_WRITE)
            begin
                t_reg[{in_row, in_col}] <= in_value;
            end
            if (accept && in_cmd == m4t_pkg::CMD_OPWRITE)
            begin
                o_reg[{in_row, in_col}] <= in_value;
            end
            if (accept && in_cmd == m4t_pkg::CMD_IDENTITY)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    t_reg[i] <= (i % 5 == 0) ? ONE : '0;
                end
            end
            if (issue_d1_reg && cmd_reg == m4t_pkg::CMD_SCALE)
            begin
                for (int i = 0; i < m4t_pkg::LANES; i++)
                begin
                    t_reg[{2'(i), kd1_reg}] <= lane_sprod[i];
                end
            end
            if (state_reg == m4t_pkg::S_EMIT && cmd_reg == m4t_pkg::CMD_MULTIPLY)
            begin
                for (int i = 0; i < m4t_pkg::LANES; i++)
                begin
                    t_reg[{rowc_reg, 2'(i)}] <= sat_val[i];
                end
            end
        end
    end

    for (genvar g = 0; g < m4t_pkg::LANES; g++)
    begin : g_lane
        m4t_lane #(
            .FRAC_BITS (FRAC_BITS),
            .WORD_BITS (WORD_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .issue (issue),
            .first (first),
            .a     (lane_a[g]),
            .b     (lane_b[g]),
            .sprod (lane_sprod[g]),
            .acc   (lane_acc[g]),
            .clip  (lane_clip[g])
        );
    end

    m4t_merge #(
        .WORD_BITS (WORD_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_acc  (lane_acc),
        .lane_clip (lane_clip),
        .rd_row    (rd_row),
        .ctl       (ctl),
        .sat_val   (sat_val),
        .free      (free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word),
        .out_row   (m_tuser[1:0]),
        .out_last  (m_tlast),
        .out_sat   (m_tuser[2])
    );

    assign m_tdata = OUT_DW'({out_word[3], out_word[2], out_word[1], out_word[0]});

endmodule

// ===== test/matrix4_transform_unit_tb.sv =====
// Testbench for the 4x4 matrix transform unit: directed table, then random commands checked against a predictor.
`timescale 1ns / 1ps

module matrix4_transform_unit_tb;

    localparam int FB     = 16;
    localparam int WB     = 32;
    localparam int IN_DW  = ((4 + 5 * WB + 7) / 8) * 8;
    localparam int OUT_DW = ((4 * WB + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 20000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] WMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] WMIN = 32'sh8000_0000;

    typedef struct packed {
        m4t_pkg::cmd_t     command;
        logic [1:0]        row;
        logic [1:0]        col;
        logic signed [31:0] value;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] vw;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic [1:0]        row_index;
        logic              last;
        logic              saturated;
    } row_result_t;

    typedef struct {
        cmd_item_t   item;
        logic        has_result;
        row_result_t result;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata;
    logic [2:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DW-1:0] m_tdata;
    logic [2:0]        m_tuser;
    logic              m_tlast;

    logic signed [31:0] xform_m [16];
    logic signed [31:0] oper_m [16];
    row_result_t        pending_rows [$];
    stim_row_t          directed [$];

    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  idle_cycles;
    bit  long_hold;

    matrix4_transform_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] clip_word(input logic signed [65:0] v,
                                                     inout logic clipped);
        if (v > 66'sd2147483647)
        begin
            clipped = 1'b1;
            return WMAX;
        end
        if (v < -66'sd2147483648)
        begin
            clipped = 1'b1;
            return WMIN;
        end
        return v[31:0];
    endfunction

    // floor of the exact product shifted right
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 inout logic clipped);
        logic signed [65:0] p;
        p = (66'(a) * 66'(b)) >>> FB;
        return clip_word(p, clipped);
    endfunction

    function automatic logic signed [31:0] q_dot(input logic signed [31:0] x [4],
                                                 input logic signed [31:0] y [4],
                                                 inout logic clipped);
        logic signed [65:0] acc;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += 66'(q_mul(x[k], y[k], clipped));
        return clip_word(acc, clipped);
    endfunction

    function automatic row_result_t product_row(input int r);
        logic signed [31:0] x [4];
        logic signed [31:0] y [4];
        logic signed [31:0] o [4];
        logic               clipped;
        row_result_t        res;
        clipped = 1'b0;
        for (int k = 0; k < 4; k++)
            x[k] = xform_m[r * 4 + k];
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                y[k] = oper_m[k * 4 + c];
            o[c] = q_dot(x, y, clipped);
        end
        res = '{o[0], o[1], o[2], o[3], 2'(r), r == 3, clipped};
        return res;
    endfunction

    task automatic apply_command(input cmd_item_t it);
        logic signed [31:0] v [4];
        logic signed [31:0] x [4];
        logic signed [31:0] o [4];
        logic signed [31:0] nm [16];
        logic               clipped;
        row_result_t        res;
        clipped = 1'b0;
        case (it.command)
            m4t_pkg::CMD_WRITE:    xform_m[it.row * 4 + it.col] = it.value;
            m4t_pkg::CMD_IDENTITY: for (int i = 0; i < 16; i++)
                                       xform_m[i] = (i % 5 == 0) ? ONE : '0;
            m4t_pkg::CMD_SCALE:    for (int i = 0; i < 16; i++)
                                       xform_m[i] = q_mul(xform_m[i], it.value, clipped);
            m4t_pkg::CMD_XFORM:
            begin
                v = '{it.vx, it.vy, it.vz, it.vw};
                for (int r = 0; r < 4; r++)
                begin
                    for (int k = 0; k < 4; k++)
                        x[k] = xform_m[r * 4 + k];
                    o[r] = q_dot(x, v, clipped);
                end
                pending_rows.push_back('{o[0], o[1], o[2], o[3], 2'd0, 1'b1, clipped});
            end
            m4t_pkg::CMD_OPWRITE:  oper_m[it.row * 4 + it.col] = it.value;
            m4t_pkg::CMD_MULTIPLY:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    res = product_row(r);
                    nm[r * 4] = res.a;
                    nm[r * 4 + 1] = res.b;
                    nm[r * 4 + 2] = res.c;
                    nm[r * 4 + 3] = res.d;
                end
                xform_m = nm;
            end
            m4t_pkg::CMD_PRODUCT:  for (int r = 0; r < 4; r++)
                                       pending_rows.push_back(product_row(r));
            default:
                pending_rows.push_back('{xform_m[it.row * 4], xform_m[it.row * 4 + 1],
                                         xform_m[it.row * 4 + 2], xform_m[it.row * 4 + 3],
                                         it.row, 1'b1, 1'b0});
        endcase
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return WMAX;
            1: return WMIN;
            2: return ONE;
            3: return -ONE;
            4: return 32'($urandom);
            default: return $signed(32'($urandom_range(0, 32'h3_ffff))) - 32'sh2_0000;
        endcase
    endfunction

    function automatic cmd_item_t rand_item();
        cmd_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)      it.command = m4t_pkg::CMD_WRITE;
        else if (pick < 40) it.command = m4t_pkg::CMD_OPWRITE;
        else if (pick < 43) it.command = m4t_pkg::CMD_IDENTITY;
        else if (pick < 48) it.command = m4t_pkg::CMD_SCALE;
        else if (pick < 70) it.command = m4t_pkg::CMD_XFORM;
        else if (pick < 75) it.command = m4t_pkg::CMD_MULTIPLY;
        else if (pick < 85) it.command = m4t_pkg::CMD_PRODUCT;
        else                it.command = m4t_pkg::CMD_READ;
        it.row   = 2'($urandom);
        it.col   = 2'($urandom);
        it.value = rand_word();
        it.vx    = rand_word();
        it.vy    = rand_word();
        it.vz    = rand_word();
        it.vw    = rand_word();
        return it;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // hold valid across back-to-back transactions, drop it only for a gap
    task automatic send_item(input cmd_item_t it);
        int gap;
        gap = gap_len();
        if (items_sent % 100 < 40) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= IN_DW'({it.vw, it.vz, it.vy, it.vx, it.value, it.col, it.row});
        s_tuser  <= it.command;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        apply_command(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic cmd_item_t mk(input m4t_pkg::cmd_t c, input int r, input int k,
                                     input logic signed [31:0] v);
        cmd_item_t it;
        it = '{c, 2'(r), 2'(k), v, '0, '0, '0, '0};
        return it;
    endfunction

    task automatic add_row(input cmd_item_t it, input logic has, input row_result_t res);
        stim_row_t s;
        s.item = it;
        s.has_result = has;
        s.result = res;
        directed.push_back(s);
    endtask

    // receiver: random stalls, one long hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (results_seen % 150 > 100)
                m_tready <= 1'b1;
            else
                m_tready <= (gap_len() == 0);
        end
    end

    always @(posedge clk)
    begin
        row_result_t got;
        row_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                    m_tuser[1:0], m_tlast, m_tuser[2]};
            results_seen++;
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        cmd_item_t it;
        row_result_t z;
        int limit;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = m4t_pkg::CMD_WRITE;
        rst_n = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        long_hold = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            xform_m[i] = (i % 5 == 0) ? ONE : '0;
            oper_m[i] = '0;
        end
        z = '0;
        add_row(mk(m4t_pkg::CMD_READ, 0, 0, 0), 1, '{ONE, 0, 0, 0, 2'd0, 1'b1, 1'b0});
        add_row(mk(m4t_pkg::CMD_READ, 3, 0, 0), 1, '{0, 0, 0, ONE, 2'd3, 1'b1, 1'b0});
        add_row(mk(m4t_pkg::CMD_PRODUCT, 0, 0, 0), 1, '{0, 0, 0, 0, 2'd3, 1'b1, 1'b0});
        add_row(mk(m4t_pkg::CMD_WRITE, 1, 2, WMAX), 0, z);
        add_row(mk(m4t_pkg::CMD_WRITE, 2, 1, WMIN), 0, z);
        add_row(mk(m4t_pkg::CMD_READ, 1, 0, 0), 1, '{0, ONE, WMAX, 0, 2'd1, 1'b1, 1'b0});
        add_row(mk(m4t_pkg::CMD_SCALE, 0, 0, 32'sh0002_0000), 0, z);
        add_row(mk(m4t_pkg::CMD_READ, 2, 0, 0), 1,
                '{0, WMIN, 32'sh0002_0000, 0, 2'd2, 1'b1, 1'b0});
        add_row(mk(m4t_pkg::CMD_XFORM, 0, 0, 0), 0, z);
        add_row(mk(m4t_pkg::CMD_OPWRITE, 0, 0, WMAX), 0, z);
        add_row(mk(m4t_pkg::CMD_OPWRITE, 3, 3, WMIN), 0, z);
        add_row(mk(m4t_pkg::CMD_OPWRITE, 1, 2, -ONE), 0, z);
        add_row(mk(m4t_pkg::CMD_PRODUCT, 0, 0, 0), 0, z);
        add_row(mk(m4t_pkg::CMD_MULTIPLY, 0, 0, 0), 0, z);
        add_row(mk(m4t_pkg::CMD_READ, 1, 0, 0), 0, z);
        add_row(mk(m4t_pkg::CMD_SCALE, 0, 0, -1), 0, z);
        add_row(mk(m4t_pkg::CMD_READ, 0, 0, 0), 0, z);
        add_row(mk(m4t_pkg::CMD_IDENTITY, 0, 0, 0), 0, z);
        add_row(mk(m4t_pkg::CMD_XFORM, 0, 0, 0), 0, z);
        add_row(mk(m4t_pkg::CMD_READ, 2, 0, 0), 1, '{0, 0, ONE, 0, 2'd2, 1'b1, 1'b0});
        directed[8].item.vx = WMAX;
        directed[8].item.vy = WMIN;
        directed[8].item.vz = WMIN;
        directed[8].item.vw = 32'sh1234_5678;
        directed[18].item.vx = -32'sd1;
        directed[18].item.vy = WMAX;
        directed[18].item.vz = 32'sh0000_8000;
        directed[18].item.vw = WMIN;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i].item);
            if (directed[i].has_result && pending_rows[$] !== directed[i].result)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: predictor %p table %p", i, pending_rows[$],
                             directed[i].result);
            end
        end
        wait_drained();

        limit = 0;
        while (items_sent < 420)
        begin
            if (items_sent == 150)
                long_hold = 1'b1;
            if (items_sent == 300)
                wait_drained();
            it = rand_item();
            send_item(it);
            limit++;
            if (limit > 2000)
                break;
        end
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        $display("Sent %0d commands of every kind, checked %0d result transactions,",
                 items_sent, results_seen);
        $display("with saturation extremes, output stalls and input backpressure.");
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== matrix4_transform_unit.f =====
hdl/m4t_pkg.sv
hdl/m4t_lane.sv
hdl/m4t_merge.sv
hdl/matrix4_transform_unit.sv
test/matrix4_transform_unit_tb.sv
